FILE: rtl/core/rmbd_pkg.sv
// Shared types and constants for the multibulk request deframer.
`default_nettype none
package rmbd_pkg;

  localparam int MAX_ARGS_BOUND = 1024;
  localparam int MAX_LEN_BOUND  = 1048576;

  localparam int CNT_W = 11;
  localparam int LEN_W = 21;
  localparam int IDX_W = 10;
  localparam int NUM_W = LEN_W + 4;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] CFG_MAX_ARGS    = 2'd0;
  localparam logic [1:0] CFG_MAX_ARG_LEN = 2'd1;

  typedef enum logic [5:0] {
    PH_STAR     = 6'b000001,
    PH_COUNT    = 6'b000010,
    PH_DOLLAR   = 6'b000100,
    PH_LEN      = 6'b001000,
    PH_DATA     = 6'b010000,
    PH_DATA_END = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    ERR_PREFIX = 3'd0,
    ERR_NUMBER = 3'd1,
    ERR_COUNT  = 3'd2,
    ERR_LENGTH = 3'd3,
    ERR_TERM   = 3'd4
  } err_code_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEN_W-1:0]   number_accum;
    logic               digit_seen;
    logic [CNT_W-1:0]   expected_args;
    logic [CNT_W-1:0]   args_done;
    logic [LEN_W-1:0]   bytes_left;
    logic [LEN_W-1:0]   current_length;
    logic               prev_was_cr;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              data_valid;
    logic [IDX_W-1:0]  arg_index;
    logic [LEN_W-1:0]  arg_length;
    logic              arg_start;
    logic              arg_end;
    logic              cmd_end;
    logic [CNT_W-1:0]  arg_count;
    logic              error;
    err_code_t         error_code;
  } parse_result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:          PH_STAR,
    number_accum:   '0,
    digit_seen:     1'b0,
    expected_args:  '0,
    args_done:      '0,
    bytes_left:     '0,
    current_length: '0,
    prev_was_cr:    1'b0
  };

endpackage
`default_nettype wire

FILE: rtl/core/rmbd_parse.sv
// Next-state and result logic for one request byte.
`default_nettype none
module rmbd_parse (
  input  var rmbd_pkg::parse_state_t           st,
  input  wire logic [7:0]                      in_byte,
  input  wire logic [rmbd_pkg::CNT_W-1:0]      lim_args,
  input  wire logic [rmbd_pkg::LEN_W-1:0]      lim_len,
  output rmbd_pkg::parse_state_t               st_next,
  output rmbd_pkg::parse_result_t              res
);

  logic                         is_digit;
  logic [rmbd_pkg::NUM_W-1:0]   num_value;
  logic [rmbd_pkg::LEN_W-1:0]   num_limit;
  logic                         num_over;
  logic [rmbd_pkg::LEN_W-1:0]   left_dec;
  logic [rmbd_pkg::CNT_W-1:0]   done_inc;

  assign is_digit  = (in_byte >= rmbd_pkg::CH_ZERO) && (in_byte <= rmbd_pkg::CH_NINE);
  assign num_limit = (st.phase == rmbd_pkg::PH_COUNT)
                     ? rmbd_pkg::LEN_W'(lim_args) : lim_len;
  // accum * 10 as two shifts
  assign num_value = (rmbd_pkg::NUM_W'(st.number_accum) << 3)
                   + (rmbd_pkg::NUM_W'(st.number_accum) << 1)
                   + rmbd_pkg::NUM_W'(8'(in_byte - rmbd_pkg::CH_ZERO));
  assign num_over  = num_value > rmbd_pkg::NUM_W'(num_limit);
  assign left_dec  = st.bytes_left - rmbd_pkg::LEN_W'(1);
  assign done_inc  = st.args_done + rmbd_pkg::CNT_W'(1);

  always_comb begin
    logic num_done;
    logic num_err;
    rmbd_pkg::err_code_t num_code;

    st_next        = st;
    res.data_byte  = '0;
    res.data_valid = 1'b0;
    res.arg_index  = st.args_done[rmbd_pkg::IDX_W-1:0];
    res.arg_length = st.current_length;
    res.arg_start  = 1'b0;
    res.arg_end    = 1'b0;
    res.cmd_end    = 1'b0;
    res.arg_count  = st.expected_args;
    res.error      = 1'b0;
    res.error_code = rmbd_pkg::ERR_PREFIX;

    // shared decimal-number step for the count and length lines
    num_done = 1'b0;
    num_err  = 1'b0;
    num_code = rmbd_pkg::ERR_NUMBER;
    if (st.prev_was_cr) begin
      if (in_byte == rmbd_pkg::CH_LF) begin
        num_done = 1'b1;
      end else begin
        num_err  = 1'b1;
        num_code = rmbd_pkg::ERR_TERM;
      end
    end else if (is_digit) begin
      if (num_over) begin
        num_err  = 1'b1;
        num_code = (st.phase == rmbd_pkg::PH_COUNT) ? rmbd_pkg::ERR_COUNT
                                                    : rmbd_pkg::ERR_LENGTH;
      end
    end else if (!(in_byte == rmbd_pkg::CH_CR && st.digit_seen)) begin
      num_err = 1'b1;
    end

    unique case (st.phase) inside
      rmbd_pkg::PH_STAR: begin
        if (in_byte == rmbd_pkg::CH_STAR) begin
          st_next.phase = rmbd_pkg::PH_COUNT;
        end else begin
          res.error = 1'b1;
        end
      end
      rmbd_pkg::PH_DOLLAR: begin
        if (in_byte == rmbd_pkg::CH_DOLLAR) begin
          st_next.phase = rmbd_pkg::PH_LEN;
        end else begin
          res.error = 1'b1;
        end
      end
      rmbd_pkg::PH_COUNT, rmbd_pkg::PH_LEN: begin
        if (num_err) begin
          res.error      = 1'b1;
          res.error_code = num_code;
        end else if (num_done) begin
          st_next.number_accum = '0;
          st_next.digit_seen   = 1'b0;
          st_next.prev_was_cr  = 1'b0;
          if (st.phase == rmbd_pkg::PH_COUNT) begin
            if (st.number_accum == '0) begin
              res.error      = 1'b1;
              res.error_code = rmbd_pkg::ERR_COUNT;
            end else begin
              st_next.expected_args = st.number_accum[rmbd_pkg::CNT_W-1:0];
              res.arg_count         = st.number_accum[rmbd_pkg::CNT_W-1:0];
              st_next.phase         = rmbd_pkg::PH_DOLLAR;
            end
          end else begin
            st_next.current_length = st.number_accum;
            st_next.bytes_left     = st.number_accum;
            res.arg_length         = st.number_accum;
            res.arg_start          = 1'b1;
            st_next.phase = (st.number_accum == '0) ? rmbd_pkg::PH_DATA_END
                                                    : rmbd_pkg::PH_DATA;
          end
        end else if (is_digit) begin
          st_next.number_accum = num_value[rmbd_pkg::LEN_W-1:0];
          st_next.digit_seen   = 1'b1;
        end else begin
          st_next.prev_was_cr = 1'b1;
        end
      end
      rmbd_pkg::PH_DATA: begin
        if (st.prev_was_cr && in_byte == rmbd_pkg::CH_LF) begin
          // CR LF before the declared length ran out
          res.error      = 1'b1;
          res.error_code = rmbd_pkg::ERR_TERM;
        end else begin
          res.data_valid = 1'b1;
          if (st.args_done == '0 && in_byte >= rmbd_pkg::CH_UPPER_A
              && in_byte <= rmbd_pkg::CH_UPPER_Z) begin
            res.data_byte = in_byte + rmbd_pkg::CASE_OFFSET;
          end else begin
            res.data_byte = in_byte;
          end
          st_next.bytes_left  = left_dec;
          st_next.prev_was_cr = (in_byte == rmbd_pkg::CH_CR);
          if (left_dec == '0) begin
            st_next.phase       = rmbd_pkg::PH_DATA_END;
            st_next.prev_was_cr = 1'b0;
          end
        end
      end
      default: begin
        if (!st.prev_was_cr) begin
          if (in_byte == rmbd_pkg::CH_CR && st.phase == rmbd_pkg::PH_DATA_END) begin
            st_next.prev_was_cr = 1'b1;
          end else begin
            res.error      = 1'b1;
            res.error_code = rmbd_pkg::ERR_TERM;
          end
        end else if (in_byte == rmbd_pkg::CH_LF) begin
          res.arg_end = 1'b1;
          if (done_inc >= st.expected_args) begin
            res.cmd_end = 1'b1;
            st_next     = rmbd_pkg::STATE_CLEAR;
          end else begin
            st_next.prev_was_cr = 1'b0;
            st_next.args_done   = done_inc;
            st_next.phase       = rmbd_pkg::PH_DOLLAR;
          end
        end else begin
          res.error      = 1'b1;
          res.error_code = rmbd_pkg::ERR_TERM;
        end
      end
    endcase

    if (res.error) begin
      st_next        = rmbd_pkg::STATE_CLEAR;
      res.data_byte  = '0;
      res.data_valid = 1'b0;
      res.arg_start  = 1'b0;
      res.arg_end    = 1'b0;
      res.cmd_end    = 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/resp_multibulk_request_deframer_core.sv
// Top level of the multibulk request deframer: byte stage, parser, result register.
//
// Request bytes enter on req_valid/in_byte; the block holds req_stall high when it
// cannot take one. Every accepted byte yields exactly one result on rsp_valid and
// the result ports, in order; the receiver holds rsp_stall high to pause them.
// A byte is captured in an input register, parsed by short logic against the
// parser state, and its result lands in the output register, so every result
// is registered behind both. One byte per cycle is sustained while rsp_stall
// stays low; the single parser state register, updated once per byte, sets that.
// While a result waits under rsp_stall, one more byte is still taken into the
// input register; after that req_stall rises until the result is taken.
// Limits are written on cfg_valid/cfg_ready/cfg_index/cfg_data (cfg_ready is
// always high): index 0 is the largest argument count (low 11 bits of cfg_data),
// index 1 the largest argument length; limits over the hardware bounds are clipped.
// Reset (rst, synchronous) empties both registers, returns the parser to
// waiting for '*' and restores both limits to their default values.
`default_nettype none
module resp_multibulk_request_deframer_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [7:0]                   in_byte,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [7:0]                        data_byte,
  output logic                              data_valid,
  output logic [rmbd_pkg::IDX_W-1:0]        arg_index,
  output logic [rmbd_pkg::LEN_W-1:0]        arg_length,
  output logic                              arg_start,
  output logic                              arg_end,
  output logic                              cmd_end,
  output logic [rmbd_pkg::CNT_W-1:0]        arg_count,
  output logic                              error,
  output logic [2:0]                        error_code,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [rmbd_pkg::LEN_W-1:0]   cfg_data
);

  logic [rmbd_pkg::CNT_W-1:0] max_args;
  logic [rmbd_pkg::LEN_W-1:0] max_arg_len;
  logic [rmbd_pkg::CNT_W-1:0] lim_args;
  logic [rmbd_pkg::LEN_W-1:0] lim_len;

  logic                      byte_full;
  logic [7:0]                byte_q;
  logic                      advance;
  logic                      req_take;

  rmbd_pkg::parse_state_t    st;
  rmbd_pkg::parse_state_t    st_next;
  rmbd_pkg::parse_result_t   res_next;
  rmbd_pkg::parse_result_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_args    <= rmbd_pkg::CNT_W'(rmbd_pkg::MAX_ARGS_BOUND);
      max_arg_len <= rmbd_pkg::LEN_W'(rmbd_pkg::MAX_LEN_BOUND);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rmbd_pkg::CFG_MAX_ARGS:    max_args    <= cfg_data[rmbd_pkg::CNT_W-1:0];
        rmbd_pkg::CFG_MAX_ARG_LEN: max_arg_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim_args = (max_args < rmbd_pkg::CNT_W'(rmbd_pkg::MAX_ARGS_BOUND))
                    ? max_args : rmbd_pkg::CNT_W'(rmbd_pkg::MAX_ARGS_BOUND);
  assign lim_len  = (max_arg_len < rmbd_pkg::LEN_W'(rmbd_pkg::MAX_LEN_BOUND))
                    ? max_arg_len : rmbd_pkg::LEN_W'(rmbd_pkg::MAX_LEN_BOUND);

  // byte moves to the result register when that register is free or draining
  assign advance   = byte_full && (!rsp_valid || !rsp_stall);
  assign req_stall = byte_full && !advance;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else if (req_take) begin
      byte_full <= 1'b1;
    end else if (advance) begin
      byte_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      byte_q <= in_byte;
    end
  end

  rmbd_parse u_parse (
    .st       (st),
    .in_byte  (byte_q),
    .lim_args (lim_args),
    .lim_len  (lim_len),
    .st_next  (st_next),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rmbd_pkg::STATE_CLEAR;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign data_byte  = res.data_byte;
  assign data_valid = res.data_valid;
  assign arg_index  = res.arg_index;
  assign arg_length = res.arg_length;
  assign arg_start  = res.arg_start;
  assign arg_end    = res.arg_end;
  assign cmd_end    = res.cmd_end;
  assign arg_count  = res.arg_count;
  assign error      = res.error;
  assign error_code = res.error_code;

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (byte_full && rsp_valid && rsp_stall))
    else $error("request stall without a held byte and a held result");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.error) |=> (st.phase == rmbd_pkg::PH_STAR))
    else $error("parser not back to initial state after an error");

  a_start_enters_data: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.arg_start)
      |=> (st.phase == rmbd_pkg::PH_DATA || st.phase == rmbd_pkg::PH_DATA_END))
    else $error("argument start did not lead into argument data");

  a_cmd_end_marks: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && cmd_end) |-> (arg_end && !error && !data_valid))
    else $error("command end without argument end");

endmodule
`default_nettype wire

FILE: bench/resp_multibulk_request_deframer_core_test.sv
// Self-checking bench for the multibulk request deframer core.
module resp_multibulk_request_deframer_core_test;
  import rmbd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register behind this index

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic rsp_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [LEN_W-1:0] cfg_data = '0;

  logic req_stall, rsp_valid, data_valid, arg_start, arg_end, cmd_end, error, cfg_ready;
  logic [7:0] data_byte;
  logic [IDX_W-1:0] arg_index;
  logic [LEN_W-1:0] arg_length;
  logic [CNT_W-1:0] arg_count;
  logic [2:0] error_code;

  resp_multibulk_request_deframer_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .in_byte(in_byte),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .data_byte(data_byte), .data_valid(data_valid), .arg_index(arg_index),
    .arg_length(arg_length), .arg_start(arg_start), .arg_end(arg_end),
    .cmd_end(cmd_end), .arg_count(arg_count), .error(error), .error_code(error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser mirror
  phase_t           ph;
  logic [LEN_W-1:0] num_acc;
  bit               got_digit;
  logic [CNT_W-1:0] want_args;
  logic [CNT_W-1:0] args_seen;
  logic [LEN_W-1:0] left_bytes;
  logic [LEN_W-1:0] cur_len;
  bit               cr_seen;
  logic [CNT_W-1:0] lim_args_reg = CNT_W'(1024);
  logic [LEN_W-1:0] lim_len_reg = LEN_W'(1048576);

  logic [7:0]    pending_bytes[$];
  parse_result_t parsed_results[$];
  parse_result_t due;

  int gap_left = 0, burst_left = 0;
  int stall_mode = 0, stall_tick = 0;
  int cycle_count = 0;
  int bytes_sent = 0, results_seen = 0, cmds_closed = 0, faults_seen = 0;
  int mismatches = 0;

  function void clear_parse();
    ph = PH_STAR;
    num_acc = '0;
    got_digit = 0;
    want_args = '0;
    args_seen = '0;
    left_bytes = '0;
    cur_len = '0;
    cr_seen = 0;
  endfunction

  // one byte of a decimal number closed by CR LF: 0 more, 1 done, -1 fault
  function int take_digit(input logic [7:0] b, input int unsigned limit,
                          input err_code_t range_code, output err_code_t code);
    longint unsigned v;
    code = ERR_PREFIX;
    if (cr_seen) begin
      if (b == CH_LF) return 1;
      code = ERR_TERM;
      return -1;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      v = longint'(num_acc) * 10 + longint'(b - CH_ZERO);
      if (v > limit) begin
        code = range_code;
        return -1;
      end
      num_acc = v[LEN_W-1:0];
      got_digit = 1;
      return 0;
    end
    if (b == CH_CR && got_digit) begin
      cr_seen = 1;
      return 0;
    end
    code = ERR_NUMBER;
    return -1;
  endfunction

  function parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    err_code_t code;
    bit fault;
    int rc;
    int unsigned lim_a, lim_l;
    r = '0;
    r.arg_index = args_seen[IDX_W-1:0];
    r.arg_length = cur_len;
    r.arg_count = want_args;
    lim_a = (lim_args_reg < MAX_ARGS_BOUND) ? lim_args_reg : MAX_ARGS_BOUND;
    lim_l = (lim_len_reg < MAX_LEN_BOUND) ? lim_len_reg : MAX_LEN_BOUND;
    fault = 0;
    code = ERR_PREFIX;
    case (ph)
      PH_STAR: begin
        if (b == CH_STAR) ph = PH_COUNT;
        else fault = 1;
      end
      PH_COUNT: begin
        rc = take_digit(b, lim_a, ERR_COUNT, code);
        if (rc < 0) fault = 1;
        else if (rc == 1) begin
          if (num_acc == 0) begin
            fault = 1;
            code = ERR_COUNT;
          end else begin
            want_args = num_acc[CNT_W-1:0];
            r.arg_count = want_args;
            num_acc = '0;
            got_digit = 0;
            cr_seen = 0;
            ph = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) ph = PH_LEN;
        else fault = 1;
      end
      PH_LEN: begin
        rc = take_digit(b, lim_l, ERR_LENGTH, code);
        if (rc < 0) fault = 1;
        else if (rc == 1) begin
          cur_len = num_acc;
          left_bytes = num_acc;
          r.arg_length = cur_len;
          r.arg_start = 1'b1;
          num_acc = '0;
          got_digit = 0;
          cr_seen = 0;
          ph = (left_bytes == 0) ? PH_DATA_END : PH_DATA;
        end
      end
      PH_DATA: begin
        if (cr_seen && b == CH_LF) begin
          fault = 1;
          code = ERR_TERM;
        end else begin
          r.data_valid = 1'b1;
          r.data_byte = (args_seen == 0 && b >= CH_UPPER_A && b <= CH_UPPER_Z) ?
                        b + CASE_OFFSET : b;
          cr_seen = (b == CH_CR);
          left_bytes = left_bytes - 1'b1;
          if (left_bytes == 0) begin
            ph = PH_DATA_END;
            cr_seen = 0;
          end
        end
      end
      default: begin
        if (!cr_seen) begin
          if (b == CH_CR && ph == PH_DATA_END) cr_seen = 1;
          else begin
            fault = 1;
            code = ERR_TERM;
          end
        end else if (b == CH_LF) begin
          r.arg_end = 1'b1;
          cr_seen = 0;
          args_seen = args_seen + 1'b1;
          if (args_seen >= want_args) begin
            r.cmd_end = 1'b1;
            clear_parse();
          end else ph = PH_DOLLAR;
        end else begin
          fault = 1;
          code = ERR_TERM;
        end
      end
    endcase
    if (fault) begin
      clear_parse();
      r.data_byte = '0;
      r.data_valid = 1'b0;
      r.arg_start = 1'b0;
      r.arg_end = 1'b0;
      r.cmd_end = 1'b0;
      r.error = 1'b1;
      r.error_code = code;
    end
    return r;
  endfunction

  // request driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        parsed_results = {parsed_results, parse_byte(in_byte)};
        bytes_sent++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          req_valid <= 1'b1;
          in_byte <= pending_bytes.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  function void match_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result monitor; stall pattern switches mode every so often
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= (stall_tick % 5 < 2);
    endcase
    if (!rst && rsp_valid && !rsp_stall) begin
      if (parsed_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        due = parsed_results.pop_front();
        results_seen++;
        if (due.cmd_end) cmds_closed++;
        if (due.error) faults_seen++;
        match_field("data_byte", due.data_byte, data_byte);
        match_field("data_valid", due.data_valid, data_valid);
        match_field("arg_index", due.arg_index, arg_index);
        match_field("arg_length", due.arg_length, arg_length);
        match_field("arg_start", due.arg_start, arg_start);
        match_field("arg_end", due.arg_end, arg_end);
        match_field("cmd_end", due.cmd_end, cmd_end);
        match_field("arg_count", due.arg_count, arg_count);
        match_field("error", due.error, error);
        match_field("error_code", due.error_code, error_code);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL resp_multibulk_request_deframer_core");
      $finish;
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes = {pending_bytes, s[i]};
  endtask

  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 3))
      0: return CH_UPPER_A + 8'($urandom_range(0, 25));
      1: return CH_UPPER_A + CASE_OFFSET + 8'($urandom_range(0, 25));
      2: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] spoil_byte();
    case ($urandom_range(0, 5))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_STAR;
      3: return CH_DOLLAR;
      4: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_request(int unsigned nargs, int unsigned len_cap, bit spoil);
    logic [7:0] q[$];
    string s;
    int unsigned n;
    int unsigned pos;
    s = ($urandom_range(0, 7) == 0) ? "*0" : "*";  // leading zero now and then
    s = {s, $sformatf("%0d\r\n", nargs)};
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    for (int a = 0; a < nargs; a++) begin
      n = $urandom_range(0, len_cap);
      s = $sformatf("$%0d\r\n", n);
      for (int i = 0; i < s.len(); i++) q = {q, s[i]};
      repeat (n) q = {q, content_byte()};
      q = {q, CH_CR, CH_LF};
    end
    if (spoil) begin
      pos = $urandom_range(0, q.size() - 1);
      q[pos] = spoil_byte();
    end
    pending_bytes = {pending_bytes, q};
  endtask

  task automatic add_random(int unsigned count, int unsigned arg_cap, int unsigned len_cap);
    int unsigned target;
    int unsigned pick;
    target = pending_bytes.size() + count;
    while (pending_bytes.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) add_request($urandom_range(1, arg_cap), len_cap, 0);
      else if (pick < 8) add_request($urandom_range(1, arg_cap + 1), len_cap + 1, 1);
      else if (pick == 8) add_request(arg_cap + 1, len_cap, 0);
      else repeat ($urandom_range(1, 6))
        pending_bytes = {pending_bytes, 8'($urandom_range(0, 255))};
    end
  endtask

  // wait until every request byte is in and every result is out, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || req_valid || parsed_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_ARGS) lim_args_reg = value[CNT_W-1:0];
    else if (idx == CFG_MAX_ARG_LEN) lim_len_reg = value;
  endtask

  initial begin
    clear_parse();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default limits: directed cases first
    push_text("*1\r\n$4\r\nPING\r\n");
    push_text("x");                               // bad prefix at start
    push_text("*\r");                             // number with no digits
    push_text("*0\r\n");                          // zero count
    push_text("*1\rX");                           // LF missing after count
    push_text("*1\r\n#");                         // bad prefix where '$' belongs
    push_text("*1\r\n$3\r\na\r\n");               // CR LF inside data
    push_text("*1\r\n$1\r\nzz");                  // data not closed by CR LF
    push_text("*1025");                           // count over the limit
    push_text("*1\r\n$1048577");                  // length over the limit
    push_text("*2\r\n$0\r\n\r\n$1\r\nA\r\n");     // empty arg, no folding past arg 0
    push_text("*1\r\n$1048576\r\nab\r\n");        // largest length, cut short
    add_random(90, 4, 8);
    drain();

    write_limit(CFG_MAX_ARGS, LEN_W'(1));
    write_limit(CFG_MAX_ARG_LEN, '0);
    push_text("*2\r\n");
    add_random(40, 1, 0);
    drain();

    // values past the hardware bounds are clipped
    write_limit(CFG_MAX_ARGS, '1);
    write_limit(CFG_MAX_ARG_LEN, '1);
    push_text("*1025\r\n");
    push_text("*1\r\n$1048577\r\n");
    push_text("*1024\r\n$0\r\n\r\nx");            // largest count taken, then cut off
    add_random(60, 4, 8);
    drain();

    write_limit(CFG_MAX_ARGS, '0);                // every count rejected
    write_limit(CFG_SPARE, LEN_W'(5));
    add_random(20, 1, 3);
    drain();

    write_limit(CFG_MAX_ARGS, LEN_W'(3));
    write_limit(CFG_MAX_ARG_LEN, LEN_W'(5));
    add_random(90, 3, 5);
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d request bytes under five limit settings, counts up to the bound.",
             bytes_sent);
    $display("Checked %0d results: %0d commands closed, %0d protocol faults.",
             results_seen, cmds_closed, faults_seen);
    if (mismatches == 0 && parsed_results.size() == 0) begin
      $display("PASS resp_multibulk_request_deframer_core");
    end else begin
      $display("FAIL resp_multibulk_request_deframer_core");
    end
    $finish;
  end

endmodule
